// ----- design/stnh_pkg.sv -----
// Shared types and constants for the spacetime nearest-hit search unit.
// Used by the distance unit and the top level; depends on nothing.
package stnh_pkg;

   localparam int SLOTS_DEFAULT = 64;

   // item field widths
   localparam int COORD_W   = 16;
   localparam int HIT_W     = 4 * COORD_W;
   localparam int INDEX_W   = 6;
   localparam int ACTIVE_W  = 7;
   localparam int WEIGHT_W  = 10;
   localparam int CSR_W     = 10;
   localparam int MAG_W     = COORD_W;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUM3_W    = SQ_W + 2;
   localparam int WSQ_W     = SQ_W + WEIGHT_W;
   localparam int DIST_W    = WSQ_W + 1;
   localparam int OUT_DIST_W = 41;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd0;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 10'd196;  // 14 squared

   // operation codes carried in tuser
   localparam logic OP_STORE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // register indexes
   localparam logic REG_ACTIVE_COUNT = 1'b0;
   localparam logic REG_TIME_WEIGHT  = 1'b1;

   // control travelling alongside one slot through the distance pipe
   typedef struct packed {
      logic valid;
      logic last;
   } beat_type;

endpackage

// ----- design/stnh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stnh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/stnh_dist.sv -----
// Pipelined weighted squared spacetime distance, one slot per cycle.
// Depends on stnh_pkg.
module stnh_dist #(
   parameter int AW = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  stnh_pkg::beat_type                    in_beat,
   input  logic [AW-1:0]                         in_index,
   input  logic [stnh_pkg::HIT_W-1:0]            in_hit,
   input  logic [stnh_pkg::HIT_W-1:0]            query,
   input  logic [stnh_pkg::WEIGHT_W-1:0]         weight,
   output stnh_pkg::beat_type                    out_beat,
   output logic [AW-1:0]                         out_index,
   output logic [stnh_pkg::DIST_W-1:0]           out_dist
);

   localparam int CW = stnh_pkg::COORD_W;

   // stage 1: absolute differences
   stnh_pkg::beat_type           s1_beat_ff, s1_beat_in;
   logic [AW-1:0]                s1_idx_ff;
   logic [stnh_pkg::MAG_W-1:0]   s1_mag_ff [4];
   logic [stnh_pkg::MAG_W-1:0]   s1_mag_in [4];
   // stage 2: squares
   stnh_pkg::beat_type           s2_beat_ff;
   logic [AW-1:0]                s2_idx_ff;
   logic [stnh_pkg::SQ_W-1:0]    s2_sq_ff [4];
   logic [stnh_pkg::SQ_W-1:0]    s2_sq_in [4];
   // stage 3: spatial sum and weighted time term
   stnh_pkg::beat_type           s3_beat_ff;
   logic [AW-1:0]                s3_idx_ff;
   logic [stnh_pkg::SUM3_W-1:0]  s3_sum_ff, s3_sum_in;
   logic [stnh_pkg::WSQ_W-1:0]   s3_wsq_ff, s3_wsq_in;
   // stage 4: total
   stnh_pkg::beat_type           s4_beat_ff;
   logic [AW-1:0]                s4_idx_ff;
   logic [stnh_pkg::DIST_W-1:0]  s4_dist_ff, s4_dist_in;

   always_comb begin
      logic signed [CW:0] diff;
      logic [CW:0]        mag;
      s1_beat_in = in_beat;
      for (int lane = 0; lane < 4; lane++) begin
         diff = $signed({query[lane*CW + CW-1], query[lane*CW +: CW]})
              - $signed({in_hit[lane*CW + CW-1], in_hit[lane*CW +: CW]});
         mag  = diff[CW] ? (~diff + 1'b1) : diff;
         s1_mag_in[lane] = mag[stnh_pkg::MAG_W-1:0];   // |d| <= 65535
      end
   end

   always_comb begin
      for (int lane = 0; lane < 4; lane++) begin
         s2_sq_in[lane] = stnh_pkg::SQ_W'(s1_mag_ff[lane]) * stnh_pkg::SQ_W'(s1_mag_ff[lane]);
      end
   end

   always_comb begin
      s3_sum_in = stnh_pkg::SUM3_W'(s2_sq_ff[0]) + stnh_pkg::SUM3_W'(s2_sq_ff[1])
                + stnh_pkg::SUM3_W'(s2_sq_ff[2]);
      s3_wsq_in = stnh_pkg::WSQ_W'(weight) * stnh_pkg::WSQ_W'(s2_sq_ff[3]);
   end

   assign s4_dist_in = stnh_pkg::DIST_W'(s3_sum_ff) + stnh_pkg::DIST_W'(s3_wsq_ff);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_beat_ff <= '0;
         s2_beat_ff <= '0;
         s3_beat_ff <= '0;
         s4_beat_ff <= '0;
      end else begin
         s1_beat_ff <= s1_beat_in;
         s2_beat_ff <= s1_beat_ff;
         s3_beat_ff <= s2_beat_ff;
         s4_beat_ff <= s3_beat_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_idx_ff  <= in_index;
      s2_idx_ff  <= s1_idx_ff;
      s3_idx_ff  <= s2_idx_ff;
      s4_idx_ff  <= s3_idx_ff;
      s1_mag_ff  <= s1_mag_in;
      s2_sq_ff   <= s2_sq_in;
      s3_sum_ff  <= s3_sum_in;
      s3_wsq_ff  <= s3_wsq_in;
      s4_dist_ff <= s4_dist_in;
   end

   assign out_beat  = s4_beat_ff;
   assign out_index = s4_idx_ff;
   assign out_dist  = s4_dist_ff;

endmodule

// ----- design/spacetime_nearest_hit_search_unit.sv -----
// Spacetime nearest-hit search unit: hit table, scan sequencer and best-so-far tracker.
// Depends on stnh_pkg, stnh_ram and stnh_dist.
//
// Usage
//   req_*  : input items. tuser = operation (store or search). A store writes
//            x, y, z and time into the given slot if the slot is below the
//            effective count (active_count capped at SLOTS); otherwise it is
//            dropped. A store gives no result item.
//   rsp_*  : one result item per search: nearest slot, found flag and the
//            weighted squared distance dx^2+dy^2+dz^2+w*dt^2 (saturated to
//            41 bits). Lowest slot wins a tie; an empty table gives slot 0,
//            found clear, distance 0.
//   csr_*  : write-only registers: active_count, time_weight_sq.
// Timing
//   A search hands its result to the output register at the same edge at which
//   req_tready rises again. Its duration is set by the single RAM read port:
//   one slot per cycle enters the four-stage distance pipe, then the pipe
//   drains. An empty search skips the scan and the pipe. req_tready is high
//   whenever the sequencer is idle, including while a result waits. A stalled
//   rsp holds its item; a search finishing behind it waits until the output
//   register frees.
// Reset
//   Clears the sequencer, the output valid and the registers to
//   active_count 0 and time_weight_sq 196. The hit table is not cleared.
module spacetime_nearest_hit_search_unit #(
   parameter int SLOTS = stnh_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // slot[5:0], pos_x[21:6], pos_y[37:22], pos_z[53:38],
                                    // hit_time[69:54], zero fill[71:70]
   input  logic        req_tuser,   // operation
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // best_index[5:0], best_dist_sq[46:6], zero fill[47]
   output logic        rsp_tuser,   // found
   // register writes
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [stnh_pkg::CSR_W-1:0] csr_wdata
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;        // table address
   localparam int CW = $clog2(SLOTS + 1);                       // slot count
   localparam int NW = (CW > stnh_pkg::ACTIVE_W) ? CW : stnh_pkg::ACTIVE_W;
   localparam logic [stnh_pkg::OUT_DIST_W-1:0] DIST_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // registers
   logic [stnh_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic [stnh_pkg::WEIGHT_W-1:0] weight_ff, weight_in;

   // sequencer
   state_type           state_ff, state_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [AW-1:0]       k_ff, k_in;
   stnh_pkg::beat_type  rd_beat_ff, rd_beat_in;
   logic [AW-1:0]       rd_idx_ff;
   logic [stnh_pkg::HIT_W-1:0] query_ff, query_in;

   // best so far
   logic                         best_found_ff, best_found_in;
   logic [AW-1:0]                best_idx_ff, best_idx_in;
   logic [stnh_pkg::DIST_W-1:0]  best_dist_ff, best_dist_in;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [stnh_pkg::INDEX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic                                rsp_found_ff, rsp_found_in;
   logic [stnh_pkg::OUT_DIST_W-1:0]     rsp_dist_ff, rsp_dist_in;

   // item decode
   logic [stnh_pkg::INDEX_W-1:0] req_slot;
   logic                         req_accept;
   logic [NW-1:0]                act_ext, eff_n, slot_ext, best_ext;
   logic [CW-1:0]                eff;
   logic                         store_en;
   logic                         out_free;
   logic                         rd_en;

   // distance pipe
   stnh_pkg::beat_type           dist_beat;
   logic [AW-1:0]                dist_idx;
   logic [stnh_pkg::DIST_W-1:0]  dist_val;
   logic [stnh_pkg::HIT_W-1:0]   hit_word;
   logic                         better;

   assign req_slot   = req_tdata[stnh_pkg::INDEX_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // effective count: active_count capped at the table depth
   assign act_ext  = NW'(active_ff);
   assign eff_n    = (act_ext > NW'(SLOTS)) ? NW'(SLOTS) : act_ext;
   assign eff      = eff_n[CW-1:0];
   assign slot_ext = NW'(req_slot);
   assign store_en = req_accept && (req_tuser == stnh_pkg::OP_STORE) && (slot_ext < eff_n);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rd_en    = (state_ff == ST_SCAN);

   // register file
   always_comb begin
      active_in = active_ff;
      weight_in = weight_ff;
      if (csr_we) begin
         unique case (csr_index)
            stnh_pkg::REG_ACTIVE_COUNT: active_in = csr_wdata[stnh_pkg::ACTIVE_W-1:0];
            stnh_pkg::REG_TIME_WEIGHT:  weight_in = csr_wdata[stnh_pkg::WEIGHT_W-1:0];
            default:                    active_in = active_ff;
         endcase
      end
   end

   stnh_ram #(
      .WIDTH (stnh_pkg::HIT_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (slot_ext[AW-1:0]),
      .wr_data (req_tdata[stnh_pkg::INDEX_W +: stnh_pkg::HIT_W]),
      .rd_en   (rd_en),
      .rd_addr (k_ff),
      .rd_data (hit_word)
   );

   stnh_dist #(
      .AW (AW)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_beat   (rd_beat_ff),
      .in_index  (rd_idx_ff),
      .in_hit    (hit_word),
      .query     (query_ff),
      .weight    (weight_ff),
      .out_beat  (dist_beat),
      .out_index (dist_idx),
      .out_dist  (dist_val)
   );

   // strict less-than keeps the earliest slot on a tie
   assign better = !best_found_ff || (dist_val < best_dist_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      query_in      = query_ff;
      rd_beat_in    = '0;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_dist_in  = best_dist_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_dist_in   = rsp_dist_ff;

      if (dist_beat.valid && better) begin
         best_found_in = 1'b1;
         best_idx_in   = dist_idx;
         best_dist_in  = dist_val;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == stnh_pkg::OP_SEARCH)) begin
               query_in      = req_tdata[stnh_pkg::INDEX_W +: stnh_pkg::HIT_W];
               n_in          = eff;
               k_in          = '0;
               best_found_in = 1'b0;
               best_idx_in   = '0;
               best_dist_in  = '0;
               state_in      = (eff == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_beat_in.valid = 1'b1;
            if (CW'(k_ff) == n_ff - CW'(1)) begin
               rd_beat_in.last = 1'b1;
               state_in        = ST_DRAIN;
            end else begin
               k_in = k_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (dist_beat.valid && dist_beat.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = best_ext[stnh_pkg::INDEX_W-1:0];
               rsp_found_in = best_found_ff;
               rsp_dist_in  = (|best_dist_ff[stnh_pkg::DIST_W-1:stnh_pkg::OUT_DIST_W])
                            ? DIST_MAX : best_dist_ff[stnh_pkg::OUT_DIST_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      best_ext = NW'(best_idx_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= stnh_pkg::ACTIVE_RESET;
         weight_ff     <= stnh_pkg::WEIGHT_RESET;
         rd_beat_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         weight_ff     <= weight_in;
         rd_beat_ff    <= rd_beat_in;
         rsp_valid_ff  <= rsp_valid_in;
         best_found_ff <= best_found_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      k_ff         <= k_in;
      query_ff     <= query_in;
      rd_idx_ff    <= k_ff;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {1'b0, rsp_dist_ff, rsp_idx_ff};

   // scan address never runs past the count latched for this search
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CW'(k_ff) < n_ff))
      else $error("scan address beyond active count");

   // distances only arrive while a search is scanning or draining
   a_dist_in_search: assert property (@(posedge clock) disable iff (reset)
      dist_beat.valid |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)))
      else $error("distance item outside a search");

   // an empty search goes straight to the result hand-off
   a_empty_search: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == stnh_pkg::OP_SEARCH) && (eff == '0))
      |=> (state_ff == ST_DONE) && !best_found_ff)
      else $error("empty search did not complete at once");

   // a finished search loads the output register when it is free
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && out_free) |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished search did not reach the output");

endmodule

// ----- bench/stnh_checker.sv -----
`timescale 1ns / 100ps
// Checker for the spacetime nearest-hit search unit: keeps its own hit table and registers,
// predicts every search result and compares it with the rsp channel. Depends on stnh_pkg.
module stnh_checker
   import stnh_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [71:0]         req_tdata,   // slot, pos_x, pos_y, pos_z, hit_time, zero fill
   input  logic                req_tuser,   // operation
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [47:0]         rsp_tdata,   // best_index, best_dist_sq, zero fill
   input  logic                rsp_tuser,   // found
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_wdata,
   output int                  failures,
   output int                  pending,
   output int                  searches,
   output int                  found_count,
   output int                  saturated_count
);

   localparam logic [63:0] DIST_CAP = (64'd1 << OUT_DIST_W) - 64'd1;

   typedef struct packed {
      logic signed [COORD_W-1:0] t;
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } hit_type;

   typedef struct packed {
      logic [INDEX_W-1:0]    index;
      logic                  found;
      logic [OUT_DIST_W-1:0] dist_sq;
   } nearest_type;

   hit_type             hit_store [SLOTS];
   logic [ACTIVE_W-1:0] active_count;
   logic [WEIGHT_W-1:0] time_weight;
   nearest_type         nearest_q [$];

   function automatic logic [63:0] sq_diff(input logic [COORD_W-1:0] a,
                                           input logic [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic [COORD_W:0]        m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? -d : d;
      return 64'(m) * 64'(m);
   endfunction

   function automatic int effective_slots();
      return (int'(active_count) > SLOTS) ? SLOTS : int'(active_count);
   endfunction

   // full-precision scan, lowest slot wins a tie, saturate only at the end
   function automatic nearest_type nearest_of(input hit_type q);
      nearest_type r;
      logic [63:0] d;
      logic [63:0] best_d;
      r = '0;
      best_d = '0;
      for (int k = 0; k < effective_slots(); k++) begin
         d = sq_diff(q.x, hit_store[k].x) + sq_diff(q.y, hit_store[k].y)
           + sq_diff(q.z, hit_store[k].z) + 64'(time_weight) * sq_diff(q.t, hit_store[k].t);
         if (!r.found || d < best_d) begin
            r.found = 1'b1;
            r.index = INDEX_W'(k);
            best_d  = d;
         end
      end
      r.dist_sq = (best_d > DIST_CAP) ? DIST_CAP[OUT_DIST_W-1:0] : best_d[OUT_DIST_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      nearest_type want;
      nearest_type got;
      hit_type     h;
      if (reset) begin
         active_count    = ACTIVE_RESET;
         time_weight     = WEIGHT_RESET;
         nearest_q.delete();
         failures        = 0;
         searches        = 0;
         found_count     = 0;
         saturated_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_ACTIVE_COUNT)
               active_count = csr_wdata[ACTIVE_W-1:0];
            else
               time_weight = csr_wdata[WEIGHT_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got.index   = rsp_tdata[INDEX_W-1:0];
            got.found   = rsp_tuser;
            got.dist_sq = rsp_tdata[INDEX_W +: OUT_DIST_W];
            if (nearest_q.size() == 0) begin
               failures++;
               $display("%0t: result item with none expected: slot %0d found %0b dist %0d",
                        $time, got.index, got.found, got.dist_sq);
            end else begin
               want = nearest_q.pop_front();
               if (got !== want) begin
                  failures++;
                  $display("%0t: expected slot %0d found %0b dist %0d,",
                           $time, want.index, want.found, want.dist_sq);
                  $display("   got slot %0d found %0b dist %0d",
                           got.index, got.found, got.dist_sq);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            h = req_tdata[INDEX_W +: HIT_W];
            if (req_tuser == OP_STORE) begin
               if (int'(req_tdata[INDEX_W-1:0]) < effective_slots())
                  hit_store[req_tdata[INDEX_W-1:0]] = h;
            end else begin
               want = nearest_of(h);
               nearest_q.push_back(want);
               searches++;
               if (want.found)
                  found_count++;
               if (want.dist_sq == DIST_CAP[OUT_DIST_W-1:0])
                  saturated_count++;
            end
         end
      end
      pending = nearest_q.size();
   end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Top of the bench for spacetime_nearest_hit_search_unit: clock, reset, stimulus and verdict.
// Depends on stnh_pkg, the unit itself and stnh_checker, which does all the comparing.
module tb;
   import stnh_pkg::*;

   localparam int SLOTS        = SLOTS_DEFAULT;
   localparam int RANDOM_ITEMS = 1850;
   // room for a full-table search to finish, with margin, before touching registers
   localparam int DRAIN_CYCLES = SLOTS + 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   // window of the random part with neither side idling
   localparam int QUIET_FROM   = 700;
   localparam int QUIET_TO     = 1000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [71:0]      req_tdata;    // slot, pos_x, pos_y, pos_z, hit_time, zero fill
   logic             req_tuser;    // operation
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [47:0]      rsp_tdata;    // best_index, best_dist_sq, zero fill
   logic             rsp_tuser;    // found
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;

   int               failures;
   int               pending;
   int               searches;
   int               found_count;
   int               saturated_count;

   // stimulus-side bookkeeping: which slots hold a hit, so no search reads an unwritten one
   logic [SLOTS-1:0] written;
   int               eff_slots;
   int               stores_kept = 0;
   int               settings    = 0;
   int               cycle       = 0;
   logic             steady      = 1'b0;

   spacetime_nearest_hit_search_unit #(
      .SLOTS(SLOTS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   stnh_checker #(
      .SLOTS(SLOTS)
   ) result_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .failures       (failures),
      .pending        (pending),
      .searches       (searches),
      .found_count    (found_count),
      .saturated_count(saturated_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle, pending);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: stalls about a quarter of the time, never inside the quiet window
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= steady || ($urandom_range(99) >= 25);
      end
   end

   // Hit or query content. Small values give lots of equal distances and so exercise the
   // tie rule; the extremes push the weighted distance past 41 bits.
   function automatic logic [HIT_W-1:0] random_hit();
      logic [HIT_W-1:0] h;
      int               mode;
      mode = $urandom_range(99);
      for (int i = 0; i < 4; i++) begin
         if (mode < 50)
            h[i*COORD_W +: COORD_W] = COORD_W'($urandom);
         else if (mode < 85)
            h[i*COORD_W +: COORD_W] = COORD_W'($urandom_range(8)) - COORD_W'(4);
         else
            case ($urandom_range(3))
               0:       h[i*COORD_W +: COORD_W] = 16'h8000;
               1:       h[i*COORD_W +: COORD_W] = 16'h7fff;
               2:       h[i*COORD_W +: COORD_W] = 16'hffff;
               default: h[i*COORD_W +: COORD_W] = 16'h0000;
            endcase
      end
      return h;
   endfunction

   // one item on req_*; entered and left at a falling edge
   task automatic send_item(input logic op, input logic [INDEX_W-1:0] slot,
                            input logic [HIT_W-1:0] hit);
      while (!steady && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(72 - HIT_W - INDEX_W){1'b0}}, hit, slot};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic store_hit(input int slot, input logic [HIT_W-1:0] hit);
      send_item(OP_STORE, INDEX_W'(slot), hit);
      if (slot < eff_slots) begin
         written[slot] = 1'b1;
         stores_kept++;
      end
   endtask

   // slot field means nothing on a search, so it carries noise
   task automatic search_at(input logic [HIT_W-1:0] hit);
      send_item(OP_SEARCH, INDEX_W'($urandom), hit);
   endtask

   // sender holds off until every result is in, then lets any trailing store finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Both registers, only with the unit quiet. Any newly active slot that was never
   // written gets a hit straight away, so searches stay within the unit's contract.
   task automatic set_regs(input int active, input int weight);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= REG_ACTIVE_COUNT;
      csr_wdata <= CSR_W'(active);
      @(negedge clock);
      csr_index <= REG_TIME_WEIGHT;
      csr_wdata <= CSR_W'(weight);
      @(negedge clock);
      csr_we    <= 1'b0;
      eff_slots = (active > SLOTS) ? SLOTS : active;
      settings++;
      for (int s = 0; s < eff_slots; s++)
         if (!written[s])
            store_hit(s, random_hit());
   endtask

   initial begin : stimulus
      int phase;
      int span;
      int pick;
      int active;
      int weight;
      int slot;
      int counted;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = OP_STORE;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = REG_ACTIVE_COUNT;
      csr_wdata  = '0;
      written    = '0;
      eff_slots  = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part ---
      // reset values: no active slots, so searches come back empty and a store is dropped
      search_at('0);
      store_hit(0, random_hit());
      search_at(random_hit());

      // three slots; two identical hits make a tie that the lower slot must win
      set_regs(3, WEIGHT_RESET);
      store_hit(0, '0);
      store_hit(1, '0);
      store_hit(2, {16'hfffc, 16'h0004, 16'hfffc, 16'h0004});
      store_hit(3, {16'h0001, 16'h0001, 16'h0001, 16'h0001});   // beyond the count: dropped
      search_at({16'h0001, 16'h0000, 16'h0000, 16'h0000});
      search_at({16'hfffc, 16'h0004, 16'hfffc, 16'h0004});

      // heaviest weight and opposite corners: both distances overflow 41 bits, and only a
      // full-precision compare picks slot 1 over slot 0
      set_regs(2, 1023);
      store_hit(0, {16'h8000, 16'h8000, 16'h7fff, 16'h8000});
      store_hit(1, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
      search_at({16'h7fff, 16'h0000, 16'h0000, 16'h0000});

      // no weight on time at all
      set_regs(2, 0);
      search_at({16'h7fff, 16'h0001, 16'h0001, 16'h0001});

      // --- random part: phases of one register setting each ---
      phase   = 0;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         case (phase)
            0: set_regs(SLOTS, 1023);
            1: set_regs(127, 0);                   // count beyond the table saturates
            2: set_regs(SLOTS + 1, 1);
            3: set_regs(0, WEIGHT_RESET);
            default: begin
               pick = $urandom_range(99);
               if (pick < 10)
                  active = 0;
               else if (pick < 65)
                  active = $urandom_range(1, 16);
               else if (pick < 85)
                  active = $urandom_range(17, SLOTS - 1);
               else if (pick < 93)
                  active = SLOTS;
               else
                  active = $urandom_range(SLOTS + 1, 127);
               pick = $urandom_range(99);
               if (pick < 10)
                  weight = 0;
               else if (pick < 20)
                  weight = 1023;
               else
                  weight = $urandom_range(1023);
               set_regs(active, weight);
            end
         endcase

         span = $urandom_range(20, 60);
         for (int n = 0; n < span; n++) begin
            steady = (counted >= QUIET_FROM) && (counted < QUIET_TO);
            if ($urandom_range(99) < 55) begin
               search_at(random_hit());
               counted++;
            end else begin
               // mostly live slots; now and then one past the count, which is dropped
               if (eff_slots < SLOTS && $urandom_range(99) < 15)
                  slot = $urandom_range(eff_slots, SLOTS - 1);
               else if (eff_slots > 0)
                  slot = $urandom_range(eff_slots - 1);
               else
                  slot = $urandom_range(SLOTS - 1);
               store_hit(slot, random_hit());
               if (slot < eff_slots)
                  counted++;
            end
         end
         phase++;
      end

      steady = 1'b0;
      wait_idle();

      $display("covered %0d searches (%0d with a hit, %0d saturated), %0d stores kept,",
               searches, found_count, saturated_count, stores_kept);
      $display("%0d register settings including empty, full and over-range tables", settings);
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
